[rtl/core/keyframe_curve_evaluator_macros.svh]
// Assertion macros for the keyframe curve evaluator checker.
`ifndef KEYFRAME_CURVE_EVALUATOR_MACROS_SVH
`define KEYFRAME_CURVE_EVALUATOR_MACROS_SVH

// Same-cycle implication, reset masked.
`define KCE_ASSERT_NOW(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("keyframe curve evaluator check failed");

// Next-cycle implication, reset masked.
`define KCE_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("keyframe curve evaluator check failed");

`endif

[rtl/core/kce_pkg.sv]
// Package: types, codes and helpers of the keyframe curve evaluator.
`timescale 1ns / 1ps
package kce_pkg;

  localparam int TRACKS_DEF = 8;
  localparam int KEYS_DEF   = 16;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [2:0] MODE_LINEAR = 3'd0;
  localparam logic [2:0] MODE_STEP   = 3'd1;
  localparam logic [2:0] MODE_CUBIC  = 3'd2;
  localparam logic [2:0] MODE_EIN    = 3'd3;
  localparam logic [2:0] MODE_EOUT   = 3'd4;
  localparam logic [2:0] MODE_EINOUT = 3'd5;

  localparam int MUL_AW = 33;
  localparam int MUL_BW = 19;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  typedef struct packed {
    logic        [1:0]  op;
    logic        [2:0]  track;
    logic signed [15:0] frame;
    logic signed [31:0] key_value;
    logic        [2:0]  key_mode;
    logic signed [31:0] slope_in;
    logic signed [31:0] slope_out;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic        [1:0]  status;
  } out_t;

  typedef struct packed {
    logic signed [15:0] frame;
    logic signed [31:0] value;
    logic        [2:0]  mode;
    logic signed [31:0] slope_in;
    logic signed [31:0] slope_out;
  } key_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

[rtl/core/keyframe_curve_evaluator.sv]
// Top level: keyframe table per track with curve evaluation.
`timescale 1ns / 1ps
// Keyframe curve evaluator. A transaction is taken when start is high and busy
// is low; busy then stays high until the single result has been shown on
// out_payload for one cycle with out_strobe high. There is no back-pressure:
// the result must be captured in that cycle. Each transaction first walks the
// track's sorted keys through the key store's one read port, a read state and
// a check state per key, stopping at the first key at or after the frame.
// A write then shifts later keys up and a remove shifts them down, reading
// and then writing back each moved key. An evaluate between two keys, unless
// the left key is a step, runs a shift-subtract divide for t and then uses the
// single shared 33x19 multiplier: linear and eased modes scale the value
// difference by t or by an easing square, and cubic forms t squared and cubed
// and sums the Hermite terms of values and span-scaled slopes. Key counts
// clear at reset; key entries hold nothing until written, and only written
// entries are ever used.
module keyframe_curve_evaluator #(
  parameter int TRACKS         = kce_pkg::TRACKS_DEF,
  parameter int KEYS_PER_TRACK = kce_pkg::KEYS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  kce_pkg::in_t  in_payload,
  output logic          out_strobe,
  output kce_pkg::out_t out_payload
);

  localparam int TW    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int DEPTH = TRACKS * KEYS_PER_TRACK;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(KEYS_PER_TRACK);
  localparam int CW    = $clog2(KEYS_PER_TRACK + 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SRD    = 10'b0000000010,
    S_SCHK   = 10'b0000000100,
    S_DECIDE = 10'b0000001000,
    S_SHRD   = 10'b0000010000,
    S_SHWR   = 10'b0000100000,
    S_WRKEY  = 10'b0001000000,
    S_DIV    = 10'b0010000000,
    S_MATH   = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  kce_pkg::in_t  req_r, req_nxt;
  kce_pkg::key_t prev_r, prev_nxt, cur_r, cur_nxt;
  logic [CW-1:0] counts_r [TRACKS];
  logic [CW-1:0] n_r, n_nxt, p_r, p_nxt, k_r, k_nxt;
  logic          ins_r, ins_nxt;
  logic [16:0]   span_r, span_nxt, rem_r, rem_nxt;
  logic [15:0]   t_r, t_nxt;
  logic [3:0]    dcnt_r, dcnt_nxt, s_r, s_nxt;
  logic signed [19:0] t2_r, t2_nxt, t3_r, t3_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [35:0] hold_r, hold_nxt;
  logic signed [31:0] res_r, res_nxt;
  logic [1:0]    st_r, st_nxt;

  logic          cnt_we;
  logic [CW-1:0] cnt_val;
  logic [TW-1:0] tr_idx;

  // key store port
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  kce_pkg::key_t wr_data, rd_data;

  // shared multiplier
  logic signed [kce_pkg::MUL_AW-1:0] mul_a;
  logic signed [kce_pkg::MUL_BW-1:0] mul_b;
  logic signed [kce_pkg::MUL_PW-1:0] prod;

  // arithmetic helpers
  logic        [16:0] tz, uu, sq_sel;
  logic        [17:0] rem2;
  logic               ge;
  logic signed [35:0] pq, pq2;
  logic signed [19:0] h00, h01, h10, h11;
  logic signed [32:0] dv;
  logic signed [18:0] w;
  logic signed [63:0] acc_add;
  logic               hit, tv;

  function automatic logic [AW-1:0] key_addr(input logic [TW-1:0] tr,
                                             input logic [IW-1:0] ix);
    return AW'(AW'(tr) * AW'(KEYS_PER_TRACK)) + AW'(ix);
  endfunction

  function automatic logic tv_valid(input logic [2:0] tr);
    return 7'(tr) < 7'(TRACKS);
  endfunction

  kce_keymem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  kce_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod));

  assign tr_idx = TW'(req_r.track);
  assign tv     = 7'(in_payload.track) < 7'(TRACKS);
  assign hit    = (p_r < n_r) && (cur_r.frame == req_r.frame);

  assign tz     = {1'b0, t_r};
  assign uu     = 17'h10000 - tz;
  assign rem2   = {rem_r, 1'b0};
  assign ge     = rem2 >= {1'b0, span_r};
  assign pq     = 36'(prod >>> 16);
  assign pq2    = 36'(prod >>> 15);
  assign dv     = 33'(cur_r.value) - 33'(prev_r.value);

  // Hermite basis from t2/t3
  assign h00 = (t3_r <<< 1) - 20'sd3 * t2_r + 20'sd65536;
  assign h01 = 20'sd3 * t2_r - (t3_r <<< 1);
  assign h10 = t3_r - (t2_r <<< 1) + $signed({3'b000, tz});
  assign h11 = t3_r - t2_r;

  // easing: square of t, or of 1-t on the falling side
  assign sq_sel = ((prev_r.mode == kce_pkg::MODE_EOUT) ||
                   ((prev_r.mode == kce_pkg::MODE_EINOUT) && t_r[15])) ? uu : tz;

  always_comb begin
    case (prev_r.mode)
      kce_pkg::MODE_EIN:    w = 19'(pq);
      kce_pkg::MODE_EOUT:   w = 19'(36'sd65536 - pq);
      kce_pkg::MODE_EINOUT: w = t_r[15] ? 19'(36'sd65536 - pq2) : 19'(pq2);
      default:              w = $signed({2'b00, tz});
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    prev_nxt  = prev_r;
    cur_nxt   = cur_r;
    n_nxt     = n_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    ins_nxt   = ins_r;
    span_nxt  = span_r;
    rem_nxt   = rem_r;
    t_nxt     = t_r;
    dcnt_nxt  = dcnt_r;
    s_nxt     = s_r;
    t2_nxt    = t2_r;
    t3_nxt    = t3_r;
    acc_nxt   = acc_r;
    hold_nxt  = hold_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    cnt_we    = 1'b0;
    cnt_val   = n_r;
    wr_en     = 1'b0;
    wr_addr   = key_addr(tr_idx, p_r[IW-1:0]);
    wr_data   = cur_r;
    rd_addr   = key_addr(tr_idx, p_r[IW-1:0]);
    mul_a     = $signed({16'b0, tz});
    mul_b     = $signed({2'b00, tz});
    acc_add   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_payload;
          n_nxt     = tv ? counts_r[TW'(in_payload.track)] : '0;
          p_nxt     = '0;
          res_nxt   = '0;
          st_nxt    = kce_pkg::ST_OK;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (p_r == n_r) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (rd_data.frame >= req_r.frame) begin
          cur_nxt   = rd_data;
          state_nxt = S_DECIDE;
        end else begin
          prev_nxt  = rd_data;
          p_nxt     = p_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        if (req_r.op == kce_pkg::OP_WRITE) begin
          if (!tv_valid(req_r.track)) begin
            state_nxt = S_DONE;
          end else if (hit) begin
            ins_nxt   = 1'b0;
            state_nxt = S_WRKEY;
          end else if (n_r >= CW'(KEYS_PER_TRACK)) begin
            st_nxt    = kce_pkg::ST_FULL;
          end else begin
            ins_nxt   = 1'b1;
            k_nxt     = n_r;
            state_nxt = (n_r == p_r) ? S_WRKEY : S_SHRD;
          end
        end else if (req_r.op == kce_pkg::OP_REMOVE) begin
          if (hit) begin
            if (p_r + 1'b1 == n_r) begin
              cnt_we  = 1'b1;
              cnt_val = n_r - 1'b1;
            end else begin
              k_nxt     = p_r;
              state_nxt = S_SHRD;
            end
          end
        end else if (req_r.op == kce_pkg::OP_EVAL) begin
          if (n_r == '0) begin
            st_nxt = kce_pkg::ST_EMPTY;
          end else if (p_r == '0 || hit) begin
            res_nxt = cur_r.value;
          end else if (p_r == n_r || prev_r.mode == kce_pkg::MODE_STEP) begin
            res_nxt = prev_r.value;
          end else begin
            span_nxt  = 17'({cur_r.frame[15], cur_r.frame} -
                            {prev_r.frame[15], prev_r.frame});
            rem_nxt   = 17'({req_r.frame[15], req_r.frame} -
                            {prev_r.frame[15], prev_r.frame});
            dcnt_nxt  = '0;
            state_nxt = S_DIV;
          end
        end
      end
      S_SHRD: begin
        rd_addr   = key_addr(tr_idx, (req_r.op == kce_pkg::OP_WRITE) ?
                             IW'(k_r - 1'b1) : IW'(k_r + 1'b1));
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        wr_en   = 1'b1;
        wr_addr = key_addr(tr_idx, k_r[IW-1:0]);
        wr_data = rd_data;
        if (req_r.op == kce_pkg::OP_WRITE) begin
          k_nxt     = k_r - 1'b1;
          state_nxt = (k_r - 1'b1 == p_r) ? S_WRKEY : S_SHRD;
        end else begin
          k_nxt = k_r + 1'b1;
          if (k_r + 2'd2 == {1'b0, n_r}) begin
            cnt_we    = 1'b1;
            cnt_val   = n_r - 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SHRD;
          end
        end
      end
      S_WRKEY: begin
        wr_en             = 1'b1;
        wr_addr           = key_addr(tr_idx, p_r[IW-1:0]);
        wr_data.frame     = req_r.frame;
        wr_data.value     = req_r.key_value;
        wr_data.mode      = req_r.key_mode;
        wr_data.slope_in  = req_r.slope_in;
        wr_data.slope_out = req_r.slope_out;
        if (ins_r) begin
          cnt_we  = 1'b1;
          cnt_val = n_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DIV: begin
        rem_nxt  = ge ? 17'(rem2 - {1'b0, span_r}) : 17'(rem2);
        t_nxt    = {t_r[14:0], ge};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 4'd15) begin
          s_nxt     = '0;
          state_nxt = S_MATH;
        end
      end
      S_MATH: begin
        s_nxt = s_r + 1'b1;
        if (prev_r.mode == kce_pkg::MODE_CUBIC) begin
          case (s_r)
            4'd0: begin
              mul_a = $signed({16'b0, tz});
              mul_b = $signed({2'b00, tz});
            end
            4'd1: begin
              t2_nxt = 20'(pq);
              mul_a  = $signed({16'b0, tz});
              mul_b  = 19'(pq);
            end
            4'd2: begin
              t3_nxt = 20'(pq);
            end
            4'd3: begin
              mul_a = 33'(prev_r.value);
              mul_b = 19'(h00);
            end
            4'd4: begin
              acc_nxt = 64'(prod);
              mul_a   = 33'(cur_r.value);
              mul_b   = 19'(h01);
            end
            4'd5: begin
              acc_nxt = acc_r + 64'(prod);
              mul_a   = $signed({16'b0, span_r});
              mul_b   = 19'(h10);
            end
            4'd6: begin
              hold_nxt = 36'(prod);
              mul_a    = 33'(prev_r.slope_out);
              mul_b    = $signed({2'b00, prod[16:0]});
            end
            4'd7: begin
              acc_nxt = acc_r + 64'(prod);
              mul_a   = 33'(prev_r.slope_out);
              mul_b   = 19'(hold_r >>> 17);
            end
            4'd8: begin
              acc_nxt = acc_r + (64'(prod) <<< 17);
              mul_a   = $signed({16'b0, span_r});
              mul_b   = 19'(h11);
            end
            4'd9: begin
              hold_nxt = 36'(prod);
              mul_a    = 33'(cur_r.slope_in);
              mul_b    = $signed({2'b00, prod[16:0]});
            end
            4'd10: begin
              acc_nxt = acc_r + 64'(prod);
              mul_a   = 33'(cur_r.slope_in);
              mul_b   = 19'(hold_r >>> 17);
            end
            default: begin
              acc_add   = acc_r + (64'(prod) <<< 17);
              res_nxt   = kce_pkg::sat32(acc_add >>> 16);
              state_nxt = S_DONE;
            end
          endcase
        end else begin
          case (s_r)
            4'd0: begin
              mul_a = $signed({16'b0, sq_sel});
              mul_b = $signed({2'b00, sq_sel});
            end
            4'd1: begin
              mul_a = dv;
              mul_b = w;
            end
            default: begin
              acc_add   = 64'(prev_r.value) + 64'(prod >>> 16);
              res_nxt   = kce_pkg::sat32(acc_add);
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < TRACKS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cnt_we) begin
        counts_r[tr_idx] <= cnt_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    prev_r <= prev_nxt;
    cur_r  <= cur_nxt;
    n_r    <= n_nxt;
    p_r    <= p_nxt;
    k_r    <= k_nxt;
    ins_r  <= ins_nxt;
    span_r <= span_nxt;
    rem_r  <= rem_nxt;
    t_r    <= t_nxt;
    dcnt_r <= dcnt_nxt;
    s_r    <= s_nxt;
    t2_r   <= t2_nxt;
    t3_r   <= t3_nxt;
    acc_r  <= acc_nxt;
    hold_r <= hold_nxt;
    res_r  <= res_nxt;
    st_r   <= st_nxt;
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_strobe            = (state_r == S_DONE);
  assign out_payload.out_value = res_r;
  assign out_payload.status    = st_r;

endmodule

[rtl/core/kce_keymem.sv]
// Key store: one write port, one registered read port.
`timescale 1ns / 1ps
module kce_keymem #(
  parameter int DEPTH = kce_pkg::TRACKS_DEF * kce_pkg::KEYS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  kce_pkg::key_t        wr_data,
  input  logic [AW-1:0]        rd_addr,
  output kce_pkg::key_t        rd_data
);

  kce_pkg::key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/kce_mul.sv]
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module kce_mul (
  input  logic                                clk,
  input  logic signed [kce_pkg::MUL_AW-1:0]   a,
  input  logic signed [kce_pkg::MUL_BW-1:0]   b,
  output logic signed [kce_pkg::MUL_PW-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= kce_pkg::MUL_PW'(a) * kce_pkg::MUL_PW'(b);
  end

endmodule

[rtl/core/kce_checker.sv]
// Port-level checker for the keyframe curve evaluator, with its bind.
`timescale 1ns / 1ps
`include "keyframe_curve_evaluator_macros.svh"
module kce_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_strobe,
  input kce_pkg::out_t out_payload
);

  `KCE_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `KCE_ASSERT_NOW(a_strobe_busy, clk, rst_n, out_strobe, busy)
  `KCE_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe && !busy)
  `KCE_ASSERT_NOW(a_empty_zero, clk, rst_n,
                  out_strobe && out_payload.status == kce_pkg::ST_EMPTY,
                  out_payload.out_value == 32'sd0)

endmodule

bind keyframe_curve_evaluator kce_checker u_kce_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_payload(out_payload)
);

[test/keyframe_curve_evaluator_tb.sv]
// Testbench for the keyframe curve evaluator: directed and random transactions.
`timescale 1ns / 1ps
module keyframe_curve_evaluator_tb;

  localparam int NTRK      = kce_pkg::TRACKS_DEF;
  localparam int NKEY      = kce_pkg::KEYS_DEF;
  localparam int N_RANDOM  = 1520;
  localparam int IDLE_MAX  = 4000;  // far above the worst item plus the longest gap
  localparam int DRAIN_CYC = 100;

  localparam logic [1:0] OP_SPARE   = 2'd3;  // unused op code: no effect
  localparam logic [2:0] MODE_SPARE = 3'd7;  // unused mode code: linear

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  kce_pkg::in_t  in_payload = '0;
  logic out_strobe;
  kce_pkg::out_t out_payload;

  keyframe_curve_evaluator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_payload (in_payload),
    .out_strobe (out_strobe),
    .out_payload(out_payload)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the key tables, updated as each transaction is accepted.
  kce_pkg::key_t shadow_keys [NTRK][NKEY];
  int   shadow_count[NTRK];

  kce_pkg::in_t  item_backlog[$];      // transactions still to be driven
  kce_pkg::out_t awaited_results[$];   // predicted results, oldest first

  int   n_fail, n_checked, n_writes, n_evals, n_full, n_empty, n_accepted;
  int   gap_left;

  // Generator's view of which frames exist per track (order of queue = order applied).
  shortint gen_frames[NTRK][$];

  function automatic logic signed [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Curve value of a non-empty track at frame f.
  function automatic logic signed [31:0] curve_at(input int tr, input logic signed [15:0] f);
    int n, i;
    longint fl, span, t, u, w, v0, v1, d, t2, t3, h00, h10, h01, h11, tin, tout, s;
    n = shadow_count[tr];
    i = 0;
    if (f <= shadow_keys[tr][0].frame) return shadow_keys[tr][0].value;
    if (f >= shadow_keys[tr][n-1].frame) return shadow_keys[tr][n-1].value;
    while (i + 2 < n && shadow_keys[tr][i+1].frame <= f) i++;
    fl   = longint'(shadow_keys[tr][i].frame);
    span = longint'(shadow_keys[tr][i+1].frame) - fl;
    if (span <= 0) return shadow_keys[tr][i].value;
    t = ((longint'(f) - fl) * 65536) / span;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    u  = 65536 - t;
    v0 = longint'(shadow_keys[tr][i].value);
    v1 = longint'(shadow_keys[tr][i+1].value);
    d  = v1 - v0;
    case (shadow_keys[tr][i].mode)
      kce_pkg::MODE_STEP: return shadow_keys[tr][i].value;
      kce_pkg::MODE_CUBIC: begin
        t2   = (t * t) >>> 16;
        t3   = (t2 * t) >>> 16;
        h00  = 2 * t3 - 3 * t2 + 65536;
        h10  = t3 - 2 * t2 + t;
        h01  = 3 * t2 - 2 * t3;
        h11  = t3 - t2;
        tin  = longint'(shadow_keys[tr][i].slope_out) * span;
        tout = longint'(shadow_keys[tr][i+1].slope_in) * span;
        s    = h00 * v0 + h10 * tin + h01 * v1 + h11 * tout;
        return clip32(s >>> 16);
      end
      kce_pkg::MODE_EIN:  w = (t * t) >>> 16;
      kce_pkg::MODE_EOUT: w = 65536 - ((u * u) >>> 16);
      kce_pkg::MODE_EINOUT: begin
        if (t < 32768) w = (2 * t * t) >>> 16;
        else w = 65536 - ((2 * u * u) >>> 16);
      end
      default: w = t;  // linear, and the two spare mode codes
    endcase
    return clip32(v0 + ((d * w) >>> 16));
  endfunction

  // Applies one accepted transaction to the shadow tables; returns its result.
  function automatic kce_pkg::out_t apply_transaction(input kce_pkg::in_t it);
    kce_pkg::out_t r;
    int tr, n, p, k;
    logic hit;
    r  = '0;
    tr = int'(it.track);
    n  = shadow_count[tr];
    p  = 0;
    while (p < n && shadow_keys[tr][p].frame < it.frame) p++;
    hit = (p < n) && (shadow_keys[tr][p].frame == it.frame);
    case (it.op)
      kce_pkg::OP_WRITE: begin
        if (!hit && n >= NKEY) begin
          r.status = kce_pkg::ST_FULL;
        end else begin
          if (!hit) begin
            for (k = n; k > p; k--) shadow_keys[tr][k] = shadow_keys[tr][k-1];
            shadow_count[tr] = n + 1;
          end
          shadow_keys[tr][p] = '{it.frame, it.key_value, it.key_mode, it.slope_in, it.slope_out};
        end
      end
      kce_pkg::OP_REMOVE: begin
        if (hit) begin
          for (k = p; k + 1 < n; k++) shadow_keys[tr][k] = shadow_keys[tr][k+1];
          shadow_count[tr] = n - 1;
        end
      end
      kce_pkg::OP_EVAL: begin
        if (n == 0) r.status = kce_pkg::ST_EMPTY;
        else r.out_value = curve_at(tr, it.frame);
      end
      default: ;  // spare op code: no effect, zero result
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint exp_v, input longint got_v);
    n_fail++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, exp_v, got_v);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((n_accepted / 128) % 3 == 0) return 0;  // burst stretch, back to back
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Driver: one nonblocking write per signal per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        awaited_results.push_back(apply_transaction(in_payload));
        n_accepted++;
        if (in_payload.op == kce_pkg::OP_WRITE) n_writes++;
        if (in_payload.op == kce_pkg::OP_EVAL) n_evals++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (item_backlog.size() > 0) begin
          in_payload <= item_backlog.pop_front();
          start      <= 1'b1;
          gap_left   <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: a result is valid for exactly one cycle.
  always @(posedge clk) begin
    kce_pkg::out_t exp_r;
    if (rst_n && out_strobe) begin
      if (awaited_results.size() == 0) begin
        n_fail++;
        $display("%0t: result with nothing outstanding", $realtime);
      end else begin
        exp_r = awaited_results.pop_front();
        n_checked++;
        if (out_payload.out_value !== exp_r.out_value)
          report_mismatch("out_value", exp_r.out_value, out_payload.out_value);
        if (out_payload.status !== exp_r.status)
          report_mismatch("status", exp_r.status, out_payload.status);
        if (exp_r.status == kce_pkg::ST_FULL) n_full++;
        if (exp_r.status == kce_pkg::ST_EMPTY) n_empty++;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("keyframe_curve_evaluator_tb NOT OK");
      $finish;
    end
  end

  function automatic kce_pkg::in_t mk(input logic [1:0] op, input int tr, input int fr,
                                      input logic [31:0] val, input logic [2:0] mode,
                                      input logic [31:0] si, input logic [31:0] so);
    kce_pkg::in_t it;
    it.op = op; it.track = tr[2:0]; it.frame = fr[15:0];
    it.key_value = val; it.key_mode = mode; it.slope_in = si; it.slope_out = so;
    return it;
  endfunction

  function automatic logic [31:0] rnd_value();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return 32'($urandom_range(0, 2 << 20)) - 32'(1 << 20);
  endfunction

  function automatic int gen_index(input int tr, input shortint f);
    for (int j = 0; j < gen_frames[tr].size(); j++)
      if (gen_frames[tr][j] == f) return j;
    return -1;
  endfunction

  // Picks a frame: half the time existing keys or near them so hits and short spans occur.
  function automatic shortint rnd_frame(input int tr);
    int r, sz;
    r  = $urandom_range(0, 99);
    sz = gen_frames[tr].size();
    if (sz > 0 && r < 30) return gen_frames[tr][$urandom_range(0, sz - 1)];
    if (sz > 0 && r < 50)
      return shortint'(gen_frames[tr][$urandom_range(0, sz - 1)] +
                       shortint'($urandom_range(0, 8)) - 4);
    if (tr < 4) return shortint'(shortint'($urandom_range(0, 128)) - 64);
    return shortint'($urandom);
  endfunction

  // Keeps the generator's frame lists in step with what the block will do.
  task automatic queue_item(input kce_pkg::in_t it);
    int tr, idx;
    tr  = int'(it.track);
    idx = gen_index(tr, it.frame);
    if (it.op == kce_pkg::OP_WRITE && idx < 0 && gen_frames[tr].size() < NKEY)
      gen_frames[tr].push_back(it.frame);
    if (it.op == kce_pkg::OP_REMOVE && idx >= 0) gen_frames[tr].delete(idx);
    item_backlog.push_back(it);
  endtask

  initial begin
    kce_pkg::in_t it;
    int tr, r, k;
    n_fail = 0; n_checked = 0; n_writes = 0; n_evals = 0;
    n_full = 0; n_empty = 0; n_accepted = 0;
    foreach (shadow_count[j]) shadow_count[j] = 0;

    // Directed: empty track, missing remove, spare op.
    queue_item(mk(kce_pkg::OP_EVAL, 0, 5, 0, kce_pkg::MODE_LINEAR, 0, 0));
    queue_item(mk(kce_pkg::OP_REMOVE, 0, 5, 0, kce_pkg::MODE_LINEAR, 0, 0));
    queue_item(mk(OP_SPARE, 7, -1, 32'hFFFFFFFF, MODE_SPARE, 32'hFFFFFFFF, 32'hFFFFFFFF));
    // Extreme frames and values, linear span across the whole range.
    queue_item(mk(kce_pkg::OP_WRITE, 0, -32768, 32'h80000000, kce_pkg::MODE_LINEAR,
                  32'h7FFFFFFF, 32'h80000000));
    queue_item(mk(kce_pkg::OP_WRITE, 0, 32767, 32'h7FFFFFFF, kce_pkg::MODE_CUBIC,
                  32'h80000000, 32'h7FFFFFFF));
    queue_item(mk(kce_pkg::OP_EVAL, 0, 0, 0, kce_pkg::MODE_LINEAR, 0, 0));
    queue_item(mk(kce_pkg::OP_EVAL, 0, -32768, 0, kce_pkg::MODE_LINEAR, 0, 0));
    queue_item(mk(kce_pkg::OP_EVAL, 0, 32767, 0, kce_pkg::MODE_LINEAR, 0, 0));
    // Single key: held everywhere.
    queue_item(mk(kce_pkg::OP_WRITE, 1, 10, 32'h00050000, kce_pkg::MODE_CUBIC, 0, 0));
    queue_item(mk(kce_pkg::OP_EVAL, 1, -100, 0, kce_pkg::MODE_LINEAR, 0, 0));
    queue_item(mk(kce_pkg::OP_EVAL, 1, 200, 0, kce_pkg::MODE_LINEAR, 0, 0));
    // One segment per mode on track 2, keys every 16 frames; huge slopes on keys 1 and 2.
    for (k = 0; k < 8; k++)
      queue_item(mk(kce_pkg::OP_WRITE, 2, k * 16, 32'(k * 32'h00030000) - 32'h00080000,
                    k[2:0], k == 2 ? 32'h7FFFFFFF : 32'h00010000,
                    k == 1 ? 32'h7FFFFFFF : 32'hFFFF0000));
    for (k = 0; k < 7; k++)
      queue_item(mk(kce_pkg::OP_EVAL, 2, k * 16 + 5 + (k % 2) * 6, 0,
                    kce_pkg::MODE_LINEAR, 0, 0));
    queue_item(mk(kce_pkg::OP_EVAL, 2, 32, 0, kce_pkg::MODE_LINEAR, 0, 0));   // exact key
    queue_item(mk(kce_pkg::OP_WRITE, 2, 32, 32'h7FFFFFFF, kce_pkg::MODE_EINOUT, 0, 0));
    queue_item(mk(kce_pkg::OP_REMOVE, 2, 48, 0, kce_pkg::MODE_LINEAR, 0, 0));
    queue_item(mk(kce_pkg::OP_EVAL, 2, 50, 0, kce_pkg::MODE_LINEAR, 0, 0));
    // Fill track 3, then a new frame is refused and a replace still succeeds.
    for (k = 0; k < NKEY + 1; k++)
      queue_item(mk(kce_pkg::OP_WRITE, 3, k * 3 - 20, rnd_value(), 3'($urandom_range(0, 7)),
                    $urandom, $urandom));
    queue_item(mk(kce_pkg::OP_WRITE, 3, -20, 32'h00010000, kce_pkg::MODE_CUBIC,
                  $urandom, $urandom));
    queue_item(mk(kce_pkg::OP_EVAL, 3, -18, 0, kce_pkg::MODE_LINEAR, 0, 0));

    // Random: mostly writes and evaluates with hits and near misses, some noise.
    for (k = 0; k < N_RANDOM; k++) begin
      tr = $urandom_range(0, NTRK - 1);
      r  = $urandom_range(0, 99);
      it = mk(kce_pkg::OP_EVAL, tr, rnd_frame(tr), rnd_value(), 3'($urandom_range(0, 7)),
              $urandom, $urandom);
      if (r < 40) it.op = kce_pkg::OP_WRITE;
      else if (r < 55) it.op = kce_pkg::OP_REMOVE;
      else if (r < 95) it.op = kce_pkg::OP_EVAL;
      else it.op = OP_SPARE;
      queue_item(it);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (item_backlog.size() != 0 || start || awaited_results.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("%0d transactions driven (%0d writes, %0d evaluates); %0d results checked",
             n_accepted, n_writes, n_evals, n_checked);
    $display("table-full refusals: %0d, empty-track evaluates: %0d, failures: %0d",
             n_full, n_empty, n_fail);
    if (n_fail == 0 && awaited_results.size() == 0) begin
      $display("keyframe_curve_evaluator_tb OK");
    end else begin
      $display("keyframe_curve_evaluator_tb NOT OK");
    end
    $finish;
  end

endmodule
